[design/phsd_pkg.sv]
// ----------------------------------------------------------------------------
// Peak-hold spectrum decimator package
// Shared constants, register codes and the job flag type.
// ----------------------------------------------------------------------------
package phsd_pkg;

   localparam int DEF_MAX_BLOCK   = 4096;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam int RST_IN_BLOCK  = 1024;
   localparam int RST_OUT_BLOCK = 256;

   localparam int FRAC_BITS = 8;
   localparam int DROP_DB   = 6;
   localparam int DROP_Q    = DROP_DB << FRAC_BITS;
   localparam int DROP_EXT  = 12;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RESAMPLE_ON    = 2'd0,
      CSR_IN_BLOCK_SIZE  = 2'd1,
      CSR_OUT_BLOCK_SIZE = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic two;
      logic be0;
      logic re0;
   } job_flags_type;

endpackage

[design/phsd_div.sv]
// ----------------------------------------------------------------------------
// Block size divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phsd_div
   import phsd_pkg::*;
#(
   parameter int IDX_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IDX_W-1:0] dividend,
   input  logic [IDX_W-1:0] divisor,
   output logic [IDX_W-1:0] quo,
   output logic [IDX_W-1:0] rem,
   output logic             busy,
   output logic             done
);

   localparam int CNT_W = $clog2(IDX_W + 1);

   logic [IDX_W-1:0] quo_ff, quo_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [IDX_W:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[IDX_W-1]};
      ge      = (trial >= {1'b0, divisor});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(IDX_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[IDX_W-2:0], ge};
         rem_in = ge ? IDX_W'(trial - {1'b0, divisor}) : trial[IDX_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

[design/phsd_front.sv]
// ----------------------------------------------------------------------------
// Decimator front end
// Accepts samples, tracks peak and border, and builds one job per item that yields a result.
// ----------------------------------------------------------------------------
module phsd_front
   import phsd_pkg::*;
#(
   parameter int IDX_W       = 13,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          load,
   input  logic                          enable,
   input  logic [IDX_W-1:0]              quo,
   input  logic [IDX_W-1:0]              rem,
   input  logic [IDX_W-1:0]              n_size,
   input  logic [IDX_W-1:0]              m_size,
   input  logic                          bypass,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          q_full,
   output logic                          push,
   output job_flags_type                 flags,
   output logic [SAMPLE_BITS-1:0]        v0,
   output logic [SAMPLE_BITS-1:0]        v1
);

   localparam int EXT_W = SAMPLE_BITS + DROP_EXT;
   localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   function automatic logic [SAMPLE_BITS-1:0] sat_drop(input logic [SAMPLE_BITS-1:0] p);
      logic signed [EXT_W-1:0] diff;
      diff = EXT_W'(signed'(p)) - EXT_W'(DROP_Q);
      if (diff < EXT_W'(signed'(SMIN))) begin
         sat_drop = SMIN;
      end else begin
         sat_drop = diff[SAMPLE_BITS-1:0];
      end
   endfunction

   logic [IDX_W-1:0]       in_idx_ff, in_idx_in;
   logic [IDX_W-1:0]       out_idx_ff, out_idx_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [IDX_W-1:0]       border_ff, border_in;
   logic [IDX_W-1:0]       brem_ff, brem_in;

   logic                   accept;
   logic                   last;
   logic                   active;
   logic                   emit;
   logic                   flush;
   logic [SAMPLE_BITS-1:0] pk;
   logic [IDX_W-1:0]       out_n;
   logic [IDX_W:0]         rem_sum;

   assign in_ready = enable & ~q_full;
   assign accept   = in_valid & in_ready;

   always_comb begin
      last    = (in_idx_ff == n_size - IDX_W'(1));
      active  = (out_idx_ff < m_size);
      pk      = (active && (signed'(sample) > signed'(peak_ff))) ? sample : peak_ff;
      emit    = active && (in_idx_ff > border_ff);
      out_n   = out_idx_ff + IDX_W'(emit);
      flush   = last && (out_n < m_size);
      rem_sum = {1'b0, brem_ff} + {1'b0, rem};

      flags = '0;
      v0    = sample;
      v1    = SMIN;
      push  = 1'b0;

      in_idx_in  = in_idx_ff;
      out_idx_in = out_idx_ff;
      peak_in    = peak_ff;
      border_in  = border_ff;
      brem_in    = brem_ff;

      if (bypass) begin
         flags.be0 = last;
         flags.re0 = 1'b1;
         push      = accept;
      end else begin
         push    = accept && (emit || flush);
         peak_in = emit ? SMIN : pk;
         if (emit && flush) begin
            flags.two = 1'b1;
            v0        = sat_drop(pk);
         end else if (emit) begin
            flags.be0 = (out_n >= m_size);
            flags.re0 = 1'b1;
            v0        = sat_drop(pk);
         end else begin
            flags.be0 = 1'b1;
            flags.re0 = 1'b1;
            v0        = sat_drop(pk);
         end
         out_idx_in = out_n;
         if (emit) begin
            if (rem_sum >= {1'b0, m_size}) begin
               border_in = border_ff + quo + IDX_W'(1);
               brem_in   = IDX_W'(rem_sum - {1'b0, m_size});
            end else begin
               border_in = border_ff + quo;
               brem_in   = rem_sum[IDX_W-1:0];
            end
         end
      end

      if (!accept) begin
         in_idx_in  = in_idx_ff;
         out_idx_in = out_idx_ff;
         peak_in    = peak_ff;
         border_in  = border_ff;
         brem_in    = brem_ff;
      end else if (last) begin
         in_idx_in  = '0;
         out_idx_in = '0;
         peak_in    = SMIN;
         border_in  = quo;
         brem_in    = rem;
      end else begin
         in_idx_in = in_idx_ff + IDX_W'(1);
      end

      if (load) begin
         border_in = quo;
         brem_in   = rem;
      end
   end

   always_ff @(posedge clock) begin
      border_ff <= border_in;
      brem_ff   <= brem_in;
      if (reset || restart) begin
         in_idx_ff  <= '0;
         out_idx_ff <= '0;
         peak_ff    <= SMIN;
      end else begin
         in_idx_ff  <= in_idx_in;
         out_idx_ff <= out_idx_in;
         peak_ff    <= peak_in;
      end
   end

endmodule

[design/phsd_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Short register FIFO between the front end and the output stage.
// ----------------------------------------------------------------------------
module phsd_queue
   import phsd_pkg::*;
#(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= wdata;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[design/phsd_back.sv]
// ----------------------------------------------------------------------------
// Decimator output stage
// Unpacks each job into one or two result transfers.
// ----------------------------------------------------------------------------
module phsd_back
   import phsd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  job_flags_type          flags,
   input  logic [SAMPLE_BITS-1:0] v0,
   input  logic [SAMPLE_BITS-1:0] v1,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] value,
   output logic                   block_end,
   output logic                   run_end
);

   logic phase_ff, phase_in;
   logic xfer;

   assign out_valid = ~q_empty;
   assign xfer      = out_valid & out_ready;
   assign pop       = xfer & (~flags.two | phase_ff);

   always_comb begin
      value     = phase_ff ? v1 : v0;
      block_end = phase_ff ? 1'b1 : flags.be0;
      run_end   = phase_ff ? 1'b1 : flags.re0;
      phase_in  = phase_ff;
      if (pop) begin
         phase_in = 1'b0;
      end else if (xfer && flags.two) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

[design/peak_hold_spectrum_decimator.sv]
// ----------------------------------------------------------------------------
// Peak-hold spectrum decimator
// Each result is queued as its sample transfers and offered on rsp in order.
// Throughput: one sample per cycle while the job queue has room and no
//   division runs; a block's final item with two results takes two transfers.
// Reset and every write to a defined register start a block size division;
//   req_tready stays low from its start through the divider's done strobe.
// ----------------------------------------------------------------------------
module peak_hold_spectrum_decimator
   import phsd_pkg::*;
#(
   parameter int  MAX_BLOCK   = DEF_MAX_BLOCK,
   parameter int  SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_W-1:0]     req_tdata,   // sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_W-1:0]     rsp_tdata,   // value
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,   // run_end
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(MAX_BLOCK + 1);
   localparam int JOB_W = $bits(job_flags_type) + 2 * SAMPLE_BITS;

   function automatic logic [IDX_W-1:0] clamp_size(input logic [31:0] v);
      if (v == 32'd0) begin
         clamp_size = IDX_W'(1);
      end else if (v > 32'(MAX_BLOCK)) begin
         clamp_size = IDX_W'(MAX_BLOCK);
      end else begin
         clamp_size = v[IDX_W-1:0];
      end
   endfunction

   logic             on_ff, on_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] m_ff, m_in;
   logic             start_ff, start_in;
   logic             csr_wr;
   logic             bypass;

   logic [IDX_W-1:0] quo;
   logic [IDX_W-1:0] rem;
   logic             div_busy;
   logic             div_done;
   logic             enable;

   logic                   push;
   job_flags_type          f_flags;
   logic [SAMPLE_BITS-1:0] f_v0;
   logic [SAMPLE_BITS-1:0] f_v1;
   logic [JOB_W-1:0]       q_rdata;
   logic                   q_empty;
   logic                   q_full;
   logic                   pop;
   job_flags_type          b_flags;
   logic [SAMPLE_BITS-1:0] b_v0;
   logic [SAMPLE_BITS-1:0] b_v1;
   logic [SAMPLE_BITS-1:0] value;

   assign csr_ready = 1'b1;

   always_comb begin
      on_in  = on_ff;
      n_in   = n_ff;
      m_in   = m_ff;
      csr_wr = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            CSR_RESAMPLE_ON: begin
               on_in  = csr_data[0];
               csr_wr = 1'b1;
            end
            CSR_IN_BLOCK_SIZE: begin
               n_in   = clamp_size(32'(csr_data));
               csr_wr = 1'b1;
            end
            CSR_OUT_BLOCK_SIZE: begin
               m_in   = clamp_size(32'(csr_data));
               csr_wr = 1'b1;
            end
            default: begin
               csr_wr = 1'b0;
            end
         endcase
      end
      start_in = csr_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff    <= 1'b0;
         n_ff     <= clamp_size(32'(RST_IN_BLOCK));
         m_ff     <= clamp_size(32'(RST_OUT_BLOCK));
         start_ff <= 1'b1;
      end else begin
         on_ff    <= on_in;
         n_ff     <= n_in;
         m_ff     <= m_in;
         start_ff <= start_in;
      end
   end

   assign bypass = ~on_ff | (n_ff <= m_ff);
   assign enable = ~(start_ff | div_busy | div_done);

   phsd_div #(
      .IDX_W (IDX_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (n_ff),
      .divisor  (m_ff),
      .quo      (quo),
      .rem      (rem),
      .busy     (div_busy),
      .done     (div_done)
   );

   phsd_front #(
      .IDX_W       (IDX_W),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .restart  (start_ff),
      .load     (div_done),
      .enable   (enable),
      .quo      (quo),
      .rem      (rem),
      .n_size   (n_ff),
      .m_size   (m_ff),
      .bypass   (bypass),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sample   (req_tdata[SAMPLE_BITS-1:0]),
      .q_full   (q_full),
      .push     (push),
      .flags    (f_flags),
      .v0       (f_v0),
      .v1       (f_v1)
   );

   phsd_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({f_flags, f_v1, f_v0}),
      .pop   (pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .full  (q_full)
   );

   assign {b_flags, b_v1, b_v0} = q_rdata;

   phsd_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .flags     (b_flags),
      .v0        (b_v0),
      .v1        (b_v1),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .value     (value),
      .block_end (rsp_tlast),
      .run_end   (rsp_tuser)
   );

   assign rsp_tdata = TDATA_W'(value);

`ifndef SYNTH
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tuser) |=> (rsp_tvalid && rsp_tuser && rsp_tlast))
      else $error("second result of a pair missing");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ($past(div_busy) && !div_busy))
      else $error("divider done without a busy run");

   a_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index <= CSR_OUT_BLOCK_SIZE) |=> !req_tready)
      else $error("sample accepted during block restart");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (q_full && !pop) |-> !push)
      else $error("job pushed into a full queue");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak-hold spectrum decimator testbench
// Streams Q8.8 spectrum levels through the block under several block-size
// settings, predicts bins with a local peak-hold model or from directed rows
// and checks value, block end and run end of each result transfer in order.
// ----------------------------------------------------------------------------
module tb;
   import phsd_pkg::*;

   localparam int CLOCK_HALF_NS   = 5;
   localparam int RESET_CYCLES    = 11;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_TAIL      = 8;
   localparam int REPORT_LIMIT    = 10;
   localparam int LIMIT_NS        = 2_000_000;
   localparam int LEVEL_MIN       = -(1 << (DEF_SAMPLE_BITS - 1));
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic [15:0] level;
      logic        block_end;
      logic        run_end;
   } bin_type;

   typedef struct packed {
      bit      typed;
      bin_type want;
   } sample_tag_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0]   reg_value;
      logic [15:0]             level;
      bit                      typed;
      bin_type                 want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 38;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8000, 1'b1, '{16'h8000, 1'b0, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h7FFF, 1'b1, '{16'h7FFF, 1'b0, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h5555, 1'b1, '{16'h5555, 1'b0, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'hAAAA, 1'b1, '{16'hAAAA, 1'b0, 1'b1}},
      '{ROW_WRITE,  CSR_RESAMPLE_ON,    13'd1, 16'h0, 1'b0, '0},
      '{ROW_WRITE,  CSR_IN_BLOCK_SIZE,  13'd2, 16'h0, 1'b0, '0},
      '{ROW_WRITE,  CSR_OUT_BLOCK_SIZE, 13'd1, 16'h0, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8000, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8000, 1'b1, '{16'h8000, 1'b1, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h7FFF, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8000, 1'b1, '{16'h79FF, 1'b1, 1'b1}},
      '{ROW_WRITE,  CSR_IN_BLOCK_SIZE,  13'd5, 16'h0, 1'b0, '0},
      '{ROW_WRITE,  CSR_OUT_BLOCK_SIZE, 13'd4, 16'h0, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h0100, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8001, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h7FFF, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8600, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h1234, 1'b0, '0},
      '{ROW_WRITE,  CSR_IN_BLOCK_SIZE,  13'd0, 16'h0, 1'b0, '0},
      '{ROW_WRITE,  CSR_OUT_BLOCK_SIZE, 13'd0, 16'h0, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h4321, 1'b1, '{16'h4321, 1'b1, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8000, 1'b1, '{16'h8000, 1'b1, 1'b1}},
      '{ROW_WRITE,  CSR_UNUSED_INDEX,   13'h1FFF, 16'h0, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h0001, 1'b1, '{16'h0001, 1'b1, 1'b1}},
      '{ROW_WRITE,  CSR_IN_BLOCK_SIZE,  13'h1FFF, 16'h0, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h7FFF, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h8000, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h0000, 1'b0, '0},
      '{ROW_WRITE,  CSR_RESAMPLE_ON,    13'd0, 16'h0, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h7FFF, 1'b1, '{16'h7FFF, 1'b0, 1'b1}},
      '{ROW_WRITE,  CSR_OUT_BLOCK_SIZE, 13'h1FFF, 16'h0, 1'b0, '0},
      '{ROW_WRITE,  CSR_IN_BLOCK_SIZE,  13'd3, 16'h0, 1'b0, '0},
      '{ROW_WRITE,  CSR_RESAMPLE_ON,    13'h1FFF, 16'h0, 1'b0, '0},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h0AAA, 1'b1, '{16'h0AAA, 1'b0, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'h0555, 1'b1, '{16'h0555, 1'b0, 1'b1}},
      '{ROW_SAMPLE, 2'd0, 13'd0, 16'hF00F, 1'b1, '{16'hF00F, 1'b1, 1'b1}}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   bin_type        expected_bins [$];
   sample_tag_type sample_tags [$];

   logic               m_resample_on = 1'b0;
   logic [12:0]        m_in_size     = 13'(RST_IN_BLOCK);
   logic [12:0]        m_out_size    = 13'(RST_OUT_BLOCK);
   int unsigned        m_in_idx;
   int unsigned        m_out_idx;
   int unsigned        m_border;
   int unsigned        m_border_rem;
   logic signed [15:0] m_peak;

   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_requests   = 0;
   int holds_done      = 0;
   int hold_left       = 0;
   int mismatches      = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int csr_writes      = 0;

   peak_hold_spectrum_decimator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // value
      .rsp_tlast  (rsp_tlast),    // block_end
      .rsp_tuser  (rsp_tuser),    // run_end
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLOCK_HALF_NS clock = ~clock;

   function automatic int unsigned clamp_size(logic [12:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_BLOCK) return DEF_MAX_BLOCK;
      return 32'(v);
   endfunction

   function automatic logic [15:0] drop_6db(logic signed [15:0] p);
      int d;
      d = int'(p) - DROP_Q;
      if (d < LEVEL_MIN) d = LEVEL_MIN;
      return d[15:0];
   endfunction

   function automatic void restart_block();
      int unsigned n;
      int unsigned m;
      n = clamp_size(m_in_size);
      m = clamp_size(m_out_size);
      m_in_idx     = 0;
      m_out_idx    = 0;
      m_peak       = 16'(LEVEL_MIN);
      m_border     = n / m;
      m_border_rem = n % m;
   endfunction

   function automatic void apply_write(logic [CSR_INDEX_W-1:0] idx,
                                       logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_RESAMPLE_ON:    m_resample_on = val[0];
         CSR_IN_BLOCK_SIZE:  m_in_size     = val;
         CSR_OUT_BLOCK_SIZE: m_out_size    = val;
         default:            return;
      endcase
      restart_block();
   endfunction

   function automatic int decimate_level(input logic signed [15:0] s,
                                         output bin_type first, output bin_type second);
      int unsigned n;
      int unsigned m;
      logic        last;
      bit          emitted;
      int          cnt;
      n       = clamp_size(m_in_size);
      m       = clamp_size(m_out_size);
      first   = '0;
      second  = '0;
      emitted = 1'b0;
      cnt     = 0;
      if (m_in_idx >= n) m_in_idx = n - 1;
      last = (m_in_idx == n - 1);
      if (!m_resample_on || n <= m) begin
         first = '{s, last, 1'b1};
         cnt   = 1;
      end else begin
         if (m_out_idx < m) begin
            if (s > m_peak) m_peak = s;
            if (m_in_idx > m_border) begin
               m_out_idx++;
               first        = '{drop_6db(m_peak), m_out_idx >= m, 1'b1};
               emitted      = 1'b1;
               cnt          = 1;
               m_peak       = 16'(LEVEL_MIN);
               m_border     += n / m;
               m_border_rem += n % m;
               if (m_border_rem >= m) begin
                  m_border++;
                  m_border_rem -= m;
               end
            end
         end
         if (last && m_out_idx < m) begin
            if (emitted) begin
               first.run_end = 1'b0;
               second = '{drop_6db(m_peak), 1'b1, 1'b1};
            end else begin
               first = '{drop_6db(m_peak), 1'b1, 1'b1};
            end
            cnt++;
         end
      end
      if (last) restart_block();
      else m_in_idx++;
      return cnt;
   endfunction

   always @(posedge clock) begin : watch
      bin_type        got;
      bin_type        want;
      bin_type        r0;
      bin_type        r1;
      sample_tag_type tag;
      int             cnt;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_write(csr_index, csr_data);
         if (req_tvalid && req_tready) begin
            tag = '0;
            if (sample_tags.size() != 0) tag = sample_tags.pop_front();
            cnt = decimate_level(req_tdata, r0, r1);
            if (tag.typed) begin
               expected_bins.push_back(tag.want);
            end else begin
               if (cnt > 0) expected_bins.push_back(r0);
               if (cnt > 1) expected_bins.push_back(r1);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tlast, rsp_tuser};
            if (expected_bins.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("unexpected result: value %h block_end %b run_end %b",
                           got.level, got.block_end, got.run_end);
               mismatches++;
            end else begin
               want = expected_bins.pop_front();
               if (got !== want) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("mismatch: expected value %h block_end %b run_end %b, got %h %b %b",
                              want.level, want.block_end, want.run_end,
                              got.level, got.block_end, got.run_end);
                  mismatches++;
               end
               results_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_requests != holds_done) begin
         holds_done <= hold_requests;
         hold_left  <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock)
      rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 48; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 48; end
         default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
   endtask

   task automatic send_sample(input logic [15:0] s, input bit typed, input bin_type want);
      sample_tag_type tag;
      tag.typed = typed;
      tag.want  = want;
      sample_tags.push_back(tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain_bins();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      int r;
      r = $urandom_range(19);
      if (r == 0) return '0;
      if (r == 1) return 13'h1FFF;
      if (r == 2) return 13'(DEF_MAX_BLOCK);
      return 13'($urandom_range(1, 40));
   endfunction

   function automatic logic [15:0] random_level();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'h8000 + 16'($urandom_range(0, 2000));
      if (r < 15) return 16'h7FFF;
      if (r < 20) return 16'h8000;
      return 16'($urandom);
   endfunction

   initial begin
      #LIMIT_NS;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [CSR_DATA_W-1:0] on_value;
      restart_block();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_idle_mode(3);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_bins();
            write_csr(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_sample(directed_rows[i].level, directed_rows[i].typed,
                        directed_rows[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_bins();
         set_idle_mode(p % 4);
         on_value    = 13'($urandom);
         on_value[0] = (p != 2) && ($urandom_range(7) != 0);
         write_csr(CSR_IN_BLOCK_SIZE, pick_size());
         write_csr(CSR_OUT_BLOCK_SIZE, pick_size());
         write_csr(CSR_RESAMPLE_ON, on_value);
         // hold the output off long enough to back the block up into its input
         if (p == 2) hold_requests <= hold_requests + 1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 5 && i == ITEMS_PER_PHASE / 2) drain_bins();
            send_sample(random_level(), 1'b0, '0);
         end
      end

      drain_bins();
      $display("covered %0d samples, %0d result transfers, %0d register writes, %0d phases",
               items_sent, results_checked, csr_writes, PHASES);
      $display("bypass, peak decimation, size clamping, long output hold; %0d mismatches",
               mismatches);
      if (mismatches == 0 && expected_bins.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
design/phsd_pkg.sv
design/phsd_div.sv
design/phsd_front.sv
design/phsd_queue.sv
design/phsd_back.sv
design/peak_hold_spectrum_decimator.sv
bench/tb.sv
